>>> rtl/tcc_pkg.sv
// Shared types and codes of the text console cursor engine.
`timescale 1ns / 1ps
package tcc_pkg;

  // command codes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // byte codes
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // tab stops every eight columns
  localparam logic [3:0] TAB_STEP = 4'd8;
  localparam logic [6:0] TAB_MASK = 7'd7;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ch;
    logic [6:0] read_col;
    logic [5:0] read_row;
  } cmd_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic [7:0] read_char;
    logic       scrolled;
  } res_t;

endpackage

>>> rtl/text_console_cursor_engine_core.sv
// Top level of the text console cursor engine: sequencer, cursor and character store.
`timescale 1ns / 1ps
// Usage
//   Command channel: cmd_i is taken at a rising edge with start high and busy low.
//   The mode field selects put byte, read cell or clear screen (mode 3 is a no-op).
//   Result channel: done_o is high for exactly one cycle with res_o valid; the
//   transfer completes at the edge that ends that cycle. The receiver cannot
//   stall, and none is needed: busy stays high until the result has gone out.
// Sequence (from accept to the result strobe, busy the whole time)
//   printable byte: write the cell   backspace: blank the cell   CR, mode 3: none
//   read cell: RAM read (none when off screen)   tab: spaces to the next tab stop
//   scroll (newline on the last row, or a wrap there): adds a sweep in which
//     every cell is walked once through the RAM read and write ports
//   clear screen: a sweep that writes a space to every cell
//   One item is in flight at a time; the RAM port and the sequencer set the rate.
// Reset
//   rst_ni low clears cursor and sequencer. After reset a clearing pass writes
//   spaces into all ROWS*COLUMNS cells with busy high.
module text_console_cursor_engine_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  tcc_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          done_o,
  output tcc_pkg::res_t res_o
);

  import tcc_pkg::*;

  localparam int Cells   = ROWS * COLUMNS;
  localparam int AW      = $clog2(Cells);
  localparam int CW      = $clog2(Cells + 1);
  localparam int CopyLen = (ROWS - 1) * COLUMNS;

  localparam logic [6:0] ColLast = 7'(COLUMNS - 1);
  localparam logic [5:0] RowLast = 6'(ROWS - 1);

  // sequencer states
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PUT    = 4'd2;
  localparam logic [3:0] S_BSW    = 4'd3;
  localparam logic [3:0] S_RD1    = 4'd4;
  localparam logic [3:0] S_RD2    = 4'd5;
  localparam logic [3:0] S_SCROLL = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [6:0]    col_q, col_d;
  logic [5:0]    row_q, row_d;
  logic [CW-1:0] p_q, p_d;          // sweep pointer for clear and scroll
  logic [3:0]    cnt_q, cnt_d;      // cells left to put (tab expands to several)
  logic          scrolled_q, scrolled_d;
  logic [7:0]    read_char_q, read_char_d;

  // payload latched at accept
  logic [7:0]    byte_q, byte_d;
  logic [6:0]    rd_col_q, rd_col_d;
  logic [5:0]    rd_row_q, rd_row_d;

  // RAM and address unit hookup
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [5:0]    au_row;
  logic [6:0]    au_col;
  logic [AW-1:0] au_addr;

  logic          accept;
  logic          rd_in_range;

  assign accept = start && !busy;
  assign rd_in_range = ({1'b0, cmd_i.read_col} < 8'(COLUMNS)) &&
                       ({1'b0, cmd_i.read_row} < 7'(ROWS));

  tcc_addr_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_addr (
    .row_i (au_row),
    .col_i (au_col),
    .addr_o(au_addr)
  );

  tcc_ram #(
    .WIDTH(8),
    .DEPTH(Cells)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    scrolled_d  = scrolled_q;
    read_char_d = read_char_q;
    byte_d      = byte_q;
    rd_col_d    = rd_col_q;
    rd_row_d    = rd_row_q;
    we          = 1'b0;
    waddr       = p_q[AW-1:0];
    wdata       = CHAR_SPACE;
    re          = 1'b0;
    au_row      = row_q;
    au_col      = col_q;
    raddr       = au_addr;

    unique case (state_q) inside
      S_INIT, S_CLEAR: begin
        // fill every cell with space, one per cycle
        we = 1'b1;
        if (p_q == CW'(Cells - 1)) begin
          p_d     = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESP;
        end else begin
          p_d = p_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          scrolled_d  = 1'b0;
          read_char_d = '0;
          rd_col_d    = cmd_i.read_col;
          rd_row_d    = cmd_i.read_row;
          byte_d      = cmd_i.ch;
          unique case (cmd_i.mode)
            MODE_PUT: begin
              case (cmd_i.ch)
                CHAR_NL: begin
                  col_d = '0;
                  if (row_q == RowLast) begin
                    scrolled_d = 1'b1;
                    cnt_d      = '0;
                    p_d        = '0;
                    state_d    = S_SCROLL;
                  end else begin
                    row_d   = row_q + 1'b1;
                    state_d = S_RESP;
                  end
                end
                CHAR_CR: begin
                  col_d   = '0;
                  state_d = S_RESP;
                end
                CHAR_BS: begin
                  if (col_q != '0) begin
                    col_d = col_q - 1'b1;
                  end
                  state_d = S_BSW;
                end
                CHAR_TAB: begin
                  byte_d  = CHAR_SPACE;
                  cnt_d   = TAB_STEP - 4'(col_q & TAB_MASK);
                  state_d = S_PUT;
                end
                default: begin
                  cnt_d   = 4'd1;
                  state_d = S_PUT;
                end
              endcase
            end
            MODE_READ: begin
              state_d = rd_in_range ? S_RD1 : S_RESP;
            end
            MODE_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              p_d     = '0;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_PUT: begin
        // store one cell at the cursor and advance, wrapping at line end (scrolling on the last row)
        we    = 1'b1;
        waddr = au_addr;
        wdata = byte_q;
        cnt_d = cnt_q - 1'b1;
        if (col_q == ColLast) begin
          col_d = '0;
          if (row_q == RowLast) begin
            scrolled_d = 1'b1;
            p_d        = '0;
            state_d    = S_SCROLL;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = (cnt_q == 4'd1) ? S_RESP : S_PUT;
          end
        end else begin
          col_d   = col_q + 1'b1;
          state_d = (cnt_q == 4'd1) ? S_RESP : S_PUT;
        end
      end

      S_BSW: begin
        // blank the cell under the already stepped-back cursor
        we    = 1'b1;
        waddr = au_addr;
        state_d = S_RESP;
      end

      S_RD1: begin
        au_row  = rd_row_q;
        au_col  = rd_col_q;
        re      = 1'b1;
        state_d = S_RD2;
      end

      S_RD2: begin
        read_char_d = rdata;
        state_d     = S_RESP;
      end

      S_SCROLL: begin
        // read cell p+COLUMNS, write it to p in the next cycle; bottom row gets spaces
        re    = (p_q < CW'(CopyLen));
        raddr = AW'(p_q + CW'(COLUMNS));
        if (p_q != '0) begin
          we    = 1'b1;
          waddr = AW'(p_q - 1'b1);
          wdata = (p_q <= CW'(CopyLen)) ? rdata : CHAR_SPACE;
        end
        if (p_q == CW'(Cells)) begin
          p_d     = '0;
          state_d = (cnt_q != '0) ? S_PUT : S_RESP;
        end else begin
          p_d = p_q + 1'b1;
        end
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      col_q       <= '0;
      row_q       <= '0;
      p_q         <= '0;
      cnt_q       <= '0;
      scrolled_q  <= 1'b0;
      read_char_q <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      p_q         <= p_d;
      cnt_q       <= cnt_d;
      scrolled_q  <= scrolled_d;
      read_char_q <= read_char_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    rd_col_q <= rd_col_d;
    rd_row_q <= rd_row_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  assign res_o.cursor_col = col_q;
  assign res_o.cursor_row = row_q;
  assign res_o.read_char  = read_char_q;
  assign res_o.scrolled   = scrolled_q;

  // every accepted command leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  // a result transfer is a single-cycle strobe followed by idle
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= ColLast) && (row_q <= RowLast))
    else $error("cursor off screen");

  // scroll only ever runs with the cursor on the last row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL) |-> (row_q == RowLast && scrolled_q))
    else $error("scroll with cursor above last row");

endmodule

>>> rtl/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3200
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/tcc_addr_unit.sv
// Shared cell address unit: row * COLUMNS + column.
`timescale 1ns / 1ps
module tcc_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 40
) (
  input  logic [5:0]                        row_i,
  input  logic [6:0]                        col_i,
  output logic [$clog2(ROWS*COLUMNS)-1:0]   addr_o
);

  localparam int AW = $clog2(ROWS * COLUMNS);

  // constant multiplier, small operands
  assign addr_o = AW'(int'(row_i) * COLUMNS + int'(col_i));

endmodule
